// ===== rtl/core/bsm_pkg.sv =====
package bsm_pkg;

    localparam int DATA_W = 31;
    localparam int PROD_W = 62;
    localparam int OP_W   = 4;

    localparam logic [OP_W-1:0] OP_START  = 4'd0;
    localparam logic [OP_W-1:0] OP_NUM    = 4'd1;
    localparam logic [OP_W-1:0] OP_POP    = 4'd2;
    localparam logic [OP_W-1:0] OP_INV    = 4'd3;
    localparam logic [OP_W-1:0] OP_DUP    = 4'd4;
    localparam logic [OP_W-1:0] OP_SWP    = 4'd5;
    localparam logic [OP_W-1:0] OP_ADD    = 4'd6;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd9;
    localparam logic [OP_W-1:0] OP_MOD    = 4'd10;
    localparam logic [OP_W-1:0] OP_FINISH = 4'd11;

    localparam logic signed [PROD_W-1:0] VALUE_LIMIT = 62'sd1000000000;

    localparam logic [2:0] WS_VAL = 3'd0;
    localparam logic [2:0] WS_NEG = 3'd1;
    localparam logic [2:0] WS_RD  = 3'd2;
    localparam logic [2:0] WS_B   = 3'd3;
    localparam logic [2:0] WS_RES = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            rd_en;
        logic            wr_en;
        logic [2:0]      wr_sel;
        logic            cap_b;
        logic            cap_a;
        logic            alu_go;
        logic            div_go;
        logic            out_load;
        logic            out_err;
    } cmd_t;

    typedef struct packed {
        logic b_zero;
        logic range_bad;
        logic div_busy;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/bsm_div.sv =====
module bsm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bsm_pkg::DATA_W-1:0] dividend,
    input  logic [bsm_pkg::DATA_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [bsm_pkg::DATA_W-1:0] quotient,
    output logic [bsm_pkg::DATA_W-1:0] remainder
);
    import bsm_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W+1])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/bsm_dp.sv =====
module bsm_dp #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsm_pkg::cmd_t                     cmd,
    input  logic [$clog2(STACK_DEPTH)-1:0]    rd_addr,
    input  logic [$clog2(STACK_DEPTH)-1:0]    wr_addr,
    input  logic [29:0]                       value,
    output bsm_pkg::stat_t                    status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bsm_pkg::DATA_W-1:0] result,
    output logic                              is_error
);
    import bsm_pkg::*;

    logic signed [DATA_W-1:0] mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [PROD_W-1:0] res_reg, res_next;
    logic signed [DATA_W-1:0] wdata;
    logic signed [PROD_W-1:0] a_ext, b_ext, q_ext, r_ext;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] result_reg;
    logic                     is_error_reg;
    logic                     div_busy, div_done;
    logic [DATA_W-1:0]        a_mag, b_mag, quo, rem;

    assign a_mag = a_reg[DATA_W-1] ? DATA_W'(-a_reg) : DATA_W'(a_reg);
    assign b_mag = b_reg[DATA_W-1] ? DATA_W'(-b_reg) : DATA_W'(b_reg);

    bsm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_go),
        .dividend  (a_mag),
        .divisor   (b_mag),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        case (cmd.wr_sel)
            WS_VAL:  wdata = {1'b0, value};
            WS_NEG:  wdata = -rdata_reg;
            WS_RD:   wdata = rdata_reg;
            WS_B:    wdata = b_reg;
            WS_RES:  wdata = res_reg[DATA_W-1:0];
            default: wdata = rdata_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign a_ext = {{(PROD_W-DATA_W){a_reg[DATA_W-1]}}, a_reg};
    assign b_ext = {{(PROD_W-DATA_W){b_reg[DATA_W-1]}}, b_reg};
    assign q_ext = {{(PROD_W-DATA_W){1'b0}}, quo};
    assign r_ext = {{(PROD_W-DATA_W){1'b0}}, rem};

    always_comb
    begin
        res_next = res_reg;
        if (cmd.alu_go)
        begin
            case (cmd.op)
                OP_ADD:  res_next = a_ext + b_ext;
                OP_SUB:  res_next = a_ext - b_ext;
                default: res_next = a_reg * b_reg;
            endcase
        end
        else if (div_done)
        begin
            // quotient negative when signs differ, remainder follows the dividend
            if (cmd.op == OP_DIV)
            begin
                res_next = (a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) ? -q_ext : q_ext;
            end
            else
            begin
                res_next = a_reg[DATA_W-1] ? -r_ext : r_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.cap_b)
        begin
            b_reg <= rdata_reg;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rdata_reg;
        end
    end

    assign status.b_zero    = (b_reg == '0);
    assign status.range_bad = (cmd.op inside {OP_ADD, OP_SUB, OP_MUL})
                              && ((res_reg > VALUE_LIMIT) || (res_reg < -VALUE_LIMIT));
    assign status.div_busy  = div_busy;
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg   <= cmd.out_err ? '0 : rdata_reg;
            is_error_reg <= cmd.out_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign is_error  = is_error_reg;

endmodule

// ===== rtl/core/bsm_ctrl.sv =====
module bsm_ctrl #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bsm_pkg::OP_W-1:0]       operation,
    input  bsm_pkg::stat_t                 status,
    output bsm_pkg::cmd_t                  cmd,
    output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    output logic [$clog2(STACK_DEPTH)-1:0] wr_addr
);
    import bsm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_EXEC = 4'd2;
    localparam logic [3:0] S_SWP  = 4'd3;
    localparam logic [3:0] S_ALU  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_UN   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            fault_reg, fault_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [DW-1:0]   dm1, dm2;
    logic            full, empty;

    assign dm1   = depth_reg - DW'(1);
    assign dm2   = depth_reg - DW'(2);
    assign full  = (depth_reg == DW'(STACK_DEPTH));
    assign empty = (depth_reg == '0);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        fault_next = fault_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        rd_addr    = '0;
        wr_addr    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = operation;
                    if (operation == OP_START)
                    begin
                        fault_next  = 1'b0;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WS_VAL;
                        depth_next  = DW'(1);
                    end
                    else if (operation == OP_FINISH)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_FIN;
                    end
                    else if (!fault_reg && (operation inside {[OP_NUM:OP_MOD]}))
                    begin
                        case (operation)
                            OP_NUM:
                            begin
                                if (full)
                                begin
                                    fault_next = 1'b1;
                                end
                                else
                                begin
                                    cmd.wr_en  = 1'b1;
                                    cmd.wr_sel = WS_VAL;
                                    wr_addr    = depth_reg[AW-1:0];
                                    depth_next = depth_reg + DW'(1);
                                end
                            end
                            OP_POP:
                            begin
                                if (empty)
                                begin
                                    fault_next = 1'b1;
                                end
                                else
                                begin
                                    depth_next = dm1;
                                end
                            end
                            OP_INV, OP_DUP:
                            begin
                                if (empty || (operation == OP_DUP && full))
                                begin
                                    fault_next = 1'b1;
                                end
                                else
                                begin
                                    cmd.rd_en  = 1'b1;
                                    rd_addr    = dm1[AW-1:0];
                                    state_next = S_UN;
                                end
                            end
                            default:
                            begin
                                if (depth_reg < DW'(2))
                                begin
                                    fault_next = 1'b1;
                                end
                                else
                                begin
                                    cmd.rd_en  = 1'b1;
                                    rd_addr    = dm1[AW-1:0];
                                    state_next = S_RDA;
                                end
                            end
                        endcase
                    end
                end
            end
            S_UN:
            begin
                cmd.wr_en = 1'b1;
                if (op_reg == OP_INV)
                begin
                    cmd.wr_sel = WS_NEG;
                    wr_addr    = dm1[AW-1:0];
                end
                else
                begin
                    cmd.wr_sel = WS_RD;
                    wr_addr    = depth_reg[AW-1:0];
                    depth_next = depth_reg + DW'(1);
                end
                state_next = S_IDLE;
            end
            S_RDA:
            begin
                cmd.cap_b  = 1'b1;
                cmd.rd_en  = 1'b1;
                rd_addr    = dm2[AW-1:0];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.cap_a = 1'b1;
                if (op_reg == OP_SWP)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WS_RD;
                    wr_addr    = dm1[AW-1:0];
                    state_next = S_SWP;
                end
                else
                begin
                    state_next = S_ALU;
                end
            end
            S_SWP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_B;
                wr_addr    = dm2[AW-1:0];
                state_next = S_IDLE;
            end
            S_ALU:
            begin
                if (op_reg == OP_DIV || op_reg == OP_MOD)
                begin
                    if (status.b_zero)
                    begin
                        fault_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.div_go = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    cmd.alu_go = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.range_bad)
                begin
                    fault_next = 1'b1;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WS_RES;
                    wr_addr    = dm2[AW-1:0];
                    depth_next = dm1;
                end
                state_next = S_IDLE;
            end
            S_FIN:
            begin
                // hold the bottom entry until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_err  = fault_reg || (depth_reg != DW'(1));
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            fault_reg <= 1'b0;
            op_reg    <= OP_START;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            fault_reg <= fault_next;
            op_reg    <= op_next;
        end
    end

endmodule

// ===== rtl/core/bounded_stack_machine_alu.sv =====
// stack machine executor, one instruction word per accepted input
// start, num, pop and unused codes complete in idle; inv and dup write back in S_UN;
// swp and the arithmetic ops read both operands first; div and mod wait on the bit-serial
// divider; finish waits on the output register; the stack ram read is registered
// asynchronous active-low reset empties the stack and clears the error flag; ram is not cleared
module bounded_stack_machine_alu #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bsm_pkg::OP_W-1:0]          operation,
    input  logic [29:0]                       value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bsm_pkg::DATA_W-1:0] result,
    output logic                              is_error
);
    import bsm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    cmd_t          cmd;
    stat_t         status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    bsm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    bsm_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .value     (value),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .is_error  (is_error)
    );

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("finish word loaded over a pending result");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall) |-> !status.div_busy)
        else $error("input taken while divider busy");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result word appeared without a finish");
`endif

endmodule

// ===== bench/tb_bounded_stack_machine_alu.sv =====
`timescale 1ns / 100ps
module tb_bounded_stack_machine_alu;
    import bsm_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 300;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [29:0]     val;
        logic            has_exp;
        logic [30:0]     exp_result;
        logic            exp_err;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [OP_W-1:0] operation;
    logic [29:0] value;
    logic out_valid;
    logic out_stall;
    logic signed [DATA_W-1:0] result;
    logic is_error;

    bounded_stack_machine_alu #(.STACK_DEPTH(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .result(result), .is_error(is_error)
    );

    // predictor state
    logic signed [30:0] mach_stack [DEPTH];
    int unsigned mach_depth;
    logic mach_fault;

    logic [30:0] want_result [$];
    logic        want_err [$];

    int errors;
    int words_in;
    int words_out;
    int idle_cycles;
    bit quiet;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void mach_push(longint v);
        if (mach_depth >= DEPTH)
            mach_fault = 1'b1;
        else
        begin
            mach_stack[mach_depth] = v[30:0];
            mach_depth++;
        end
    endfunction

    function automatic void mach_binary(logic [OP_W-1:0] op);
        longint a, b, r;
        if (mach_depth < 2)
        begin
            mach_fault = 1'b1;
            return;
        end
        b = mach_stack[mach_depth-1];
        a = mach_stack[mach_depth-2];
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV:
            begin
                if (b == 0)
                begin
                    mach_fault = 1'b1;
                    return;
                end
                r = iabs(a) / iabs(b);
                if ((a < 0 && b > 0) || (a > 0 && b < 0))
                    r = -r;
            end
            default:
            begin
                if (b == 0)
                begin
                    mach_fault = 1'b1;
                    return;
                end
                r = iabs(a) % iabs(b);
                if (a <= 0)
                    r = -r;
            end
        endcase
        if (op <= OP_MUL && (r > 1000000000 || r < -1000000000))
        begin
            mach_fault = 1'b1;
            return;
        end
        mach_depth -= 2;
        mach_stack[mach_depth] = r[30:0];
        mach_depth++;
    endfunction

    function automatic void mach_execute(logic [OP_W-1:0] op, logic [29:0] v);
        logic signed [30:0] t;
        if (op == OP_START)
        begin
            mach_depth = 0;
            mach_fault = 1'b0;
            mach_push(longint'(v));
            return;
        end
        if (op == OP_FINISH)
        begin
            if (mach_fault || mach_depth != 1)
            begin
                want_result = {want_result, 31'd0};
                want_err = {want_err, 1'b1};
            end
            else
            begin
                want_result = {want_result, mach_stack[0]};
                want_err = {want_err, 1'b0};
            end
            return;
        end
        if (op > OP_FINISH || mach_fault)
            return;
        case (op)
            OP_NUM: mach_push(longint'(v));
            OP_POP:
                if (mach_depth == 0) mach_fault = 1'b1;
                else mach_depth--;
            OP_INV:
                if (mach_depth == 0) mach_fault = 1'b1;
                else mach_stack[mach_depth-1] = -mach_stack[mach_depth-1];
            OP_DUP:
                if (mach_depth == 0) mach_fault = 1'b1;
                else mach_push(longint'(mach_stack[mach_depth-1]));
            OP_SWP:
                if (mach_depth < 2) mach_fault = 1'b1;
                else
                begin
                    t = mach_stack[mach_depth-1];
                    mach_stack[mach_depth-1] = mach_stack[mach_depth-2];
                    mach_stack[mach_depth-2] = t;
                end
            default: mach_binary(op);
        endcase
    endfunction

    // drive one word, with random idle bursts ahead of it
    task automatic send_word(logic [OP_W-1:0] op, logic [29:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mach_execute(op, v);
        words_in++;
    endtask

    // receiver stall bursts
    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            words_out++;
            if (want_result.size() == 0)
            begin
                $error("unexpected result word: result=%0d is_error=%0b", result, is_error);
                errors++;
            end
            else
            begin
                if (result !== want_result[0])
                begin
                    $error("result: expected %0d actual %0d",
                           $signed(want_result[0]), result);
                    errors++;
                end
                if (is_error !== want_err[0])
                begin
                    $error("is_error: expected %0b actual %0b", want_err[0], is_error);
                    errors++;
                end
                void'(want_result.pop_front());
                void'(want_err.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL bounded_stack_machine_alu");
            $finish;
        end
    end

    function automatic logic [29:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 30'($urandom_range(0, 3));
            1: return 30'($urandom_range(0, 100));
            2: return 30'($urandom_range(0, 40000));
            3: return 30'($urandom_range(0, 1000000000));
            4: return 30'($urandom_range(999999990, 1000000000));
            default: return 30'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_stack_op();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 25) return OP_NUM;
        if (k < 32) return OP_POP;
        if (k < 40) return OP_INV;
        if (k < 47) return OP_DUP;
        if (k < 54) return OP_SWP;
        if (k < 64) return OP_ADD;
        if (k < 73) return OP_SUB;
        if (k < 82) return OP_MUL;
        if (k < 90) return OP_DIV;
        if (k < 97) return OP_MOD;
        return OP_W'($urandom_range(12, 15));
    endfunction

    row_t dir_rows [$];

    function automatic void add_row(logic [OP_W-1:0] op, logic [29:0] v, logic h = 1'b0,
                                    logic [30:0] r = '0, logic e = 1'b0);
        row_t x;
        x.op = op; x.val = v; x.has_exp = h; x.exp_result = r; x.exp_err = e;
        dir_rows = {dir_rows, x};
    endfunction

    initial
    begin
        int n, len;
        logic [30:0] tmp;
        errors = 0; words_in = 0; words_out = 0; idle_cycles = 0;
        quiet = 1'b0;
        mach_depth = 0; mach_fault = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_START;
        value = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(OP_FINISH, 0, 1'b1, 31'd0, 1'b1);   // empty after reset
        add_row(OP_START, 30'h3FFFFFFF);
        add_row(OP_FINISH, 0, 1'b1, 31'h3FFFFFFF, 1'b0);
        add_row(OP_START, 1000000000);
        add_row(OP_INV, 0);
        add_row(OP_FINISH, 0, 1'b1, -31'sd1000000000, 1'b0);
        add_row(OP_NUM, 1);
        add_row(OP_SUB, 0);                          // range fault
        add_row(OP_NUM, 5);                          // ignored while faulted
        add_row(OP_FINISH, 0, 1'b1, 31'd0, 1'b1);
        add_row(OP_START, 7);
        add_row(OP_NUM, 0);
        add_row(OP_DIV, 0);                          // zero divisor
        add_row(OP_FINISH, 0, 1'b1, 31'd0, 1'b1);
        add_row(OP_START, 7);
        add_row(OP_INV, 0);
        add_row(OP_NUM, 2);
        add_row(OP_DUP, 0);
        add_row(OP_SWP, 0);
        add_row(OP_POP, 0);
        add_row(OP_MOD, 0);
        add_row(OP_FINISH, 0);                       // predictor checked
        add_row(OP_START, 0);
        add_row(4'd13, 0);
        add_row(OP_ADD, 0);                          // underflow
        add_row(OP_FINISH, 0, 1'b1, 31'd0, 1'b1);
        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].op, dir_rows[i].val);
            if (dir_rows[i].has_exp && want_result.size() != 0)
            begin
                tmp = want_result[want_result.size()-1];
                if (tmp !== dir_rows[i].exp_result
                    || want_err[want_err.size()-1] !== dir_rows[i].exp_err)
                begin
                    $error("table row %0d: expected %0d/%0b, predicted %0d/%0b", i,
                           $signed(dir_rows[i].exp_result), dir_rows[i].exp_err,
                           $signed(tmp), want_err[want_err.size()-1]);
                    errors++;
                end
            end
        end

        // overflow: fill the whole stack, push once more, then start at full depth
        send_word(OP_START, 30'($urandom_range(0, 1000)));
        for (int i = 1; i < DEPTH; i++)
            send_word(OP_DUP, 0);
        send_word(OP_NUM, 1);
        send_word(OP_FINISH, 0);
        send_word(OP_START, 4);
        send_word(OP_FINISH, 0);

        // random programs, mostly well-formed
        n = 0;
        while (n < N_RANDOM)
        begin
            if (n > N_RANDOM * 4 / 5)
                quiet = 1'b1;
            if ($urandom_range(0, 9) != 0)
                send_word(OP_START, rand_value());
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_word(OP_NUM, rand_value());
                else
                    send_word(rand_stack_op(), rand_value());
                n++;
            end
            if ($urandom_range(0, 7) != 0)
                send_word(OP_FINISH, rand_value());
            n += 2;
        end
        in_valid <= 1'b0;

        n = 0;
        while (want_result.size() != 0 && n < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (want_result.size() != 0)
        begin
            $error("%0d result words never arrived", want_result.size());
            errors++;
        end
        repeat (50) @(posedge clk);
        $display("covered %0d instruction words and %0d result words,", words_in, words_out);
        $display("including full-stack overflow, range, zero divisor and underflow faults");
        if (errors == 0)
            $display("PASS bounded_stack_machine_alu");
        else
            $display("FAIL bounded_stack_machine_alu");
        $finish;
    end

endmodule
